// ===== design/pvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pvm_pkg: shared definitions for the Pike VM regex matcher
// Sizes, instruction and action codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pvm_pkg;

   // Program store depth and the widths that follow from it.
   localparam int PROG_DEPTH = 64;
   localparam int PC_W       = $clog2(PROG_DEPTH);
   localparam int LEN_W      = $clog2(PROG_DEPTH + 1);
   localparam int PLEN_W     = 7;
   localparam int CMP_W      = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
   localparam int IDX_W      = 6;
   localparam int LD_W       = ((IDX_W > PC_W) ? IDX_W : PC_W) + 1;
   localparam int OFF_W      = 7;
   localparam int TGT_W      = ((PC_W > OFF_W) ? PC_W : OFF_W) + 2;
   localparam int QDEPTH     = PROG_DEPTH + 1;
   localparam int QA_W       = $clog2(QDEPTH);
   localparam int QC_W       = $clog2(QDEPTH + 1);

   // Instruction word layout: kind, char, offset.
   localparam int KIND_W  = 3;
   localparam int CHAR_W  = 8;
   localparam int INSTR_W = KIND_W + CHAR_W + OFF_W;

   // Configuration port.
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTIAL_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRAM_LENGTH = 1'd1;

   // Request actions.
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_TEXT = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   // Instruction kinds.
   localparam logic [KIND_W-1:0] KIND_LIT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WILD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_JUMP  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SPLIT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MATCH = 3'd4;

   // Fault codes as reported.
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_PC   = 2'd1;
   localparam logic [1:0] FAULT_KIND = 2'd2;

   // Events that end a walk.
   localparam logic [1:0] EV_NONE       = 2'd0;
   localparam logic [1:0] EV_MATCH      = 2'd1;
   localparam logic [1:0] EV_FAULT_PC   = 2'd2;
   localparam logic [1:0] EV_FAULT_KIND = 2'd3;

   // Outcome of executing one instruction.
   localparam logic [1:0] EX_CONT  = 2'd0;
   localparam logic [1:0] EX_SPLIT = 2'd1;
   localparam logic [1:0] EX_MATCH = 2'd2;
   localparam logic [1:0] EX_FKIND = 2'd3;

   typedef struct packed {
      logic       load;       // write the request's instruction
      logic       start;      // open a walk for the accepted beat
      logic       scan_next;  // skip an empty slot of the thread set
      logic       rd_scan;    // read the instruction of the scanned thread
      logic       q_rd;       // pop the head of the work queue
      logic       rd_q;       // read the instruction of the popped thread
      logic       exec;       // execute the instruction just read
      logic       add2;       // add the second target of a split
      logic       commit;     // replace the thread set, record the event
      logic [1:0] ev;
      logic       emit;       // load the result register and restart
   } pvm_cmd_type;

   typedef struct packed {
      logic       decided;
      logic       scan_done;
      logic       scan_hit;
      logic       high;
      logic       q_empty;
      logic       q_fault;
      logic [1:0] ex;
      logic       at_end;
      logic       out_busy;
   } pvm_status_type;

endpackage

`default_nettype wire

// ===== design/pvm_controller.sv =====
// ----------------------------------------------------------------------------
// pvm_controller: sequencer of the Pike VM regex matcher
// Accepts request beats, steps the datapath through the scan of the thread
// set and the work queue, and hands the outcome to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvm_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [1:0]              req_action,
   output logic                         req_stall,
   input  wire pvm_pkg::pvm_status_type st,
   output pvm_pkg::pvm_cmd_type         cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_ADD2   = 4'd3;
   localparam logic [3:0] S_QREAD  = 4'd4;
   localparam logic [3:0] S_QWAIT  = 4'd5;
   localparam logic [3:0] S_DONE   = 4'd6;
   localparam logic [3:0] S_FINISH = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [1:0] ev_ff, ev_in;
   logic       from_q_ff, from_q_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      ev_in     = ev_ff;
      from_q_in = from_q_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  pvm_pkg::ACT_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  pvm_pkg::ACT_TEXT: begin
                     // Once the outcome is decided, text beats are dropped.
                     if (!st.decided) begin
                        cmd.start = 1'b1;
                        state_in  = S_SCAN;
                     end
                  end
                  pvm_pkg::ACT_END: begin
                     if (st.decided) begin
                        state_in = S_FINISH;
                     end else begin
                        cmd.start = 1'b1;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (st.scan_done) begin
               if (st.high) begin
                  ev_in    = pvm_pkg::EV_FAULT_PC;
                  state_in = S_DONE;
               end else begin
                  state_in = S_QREAD;
               end
            end else if (st.scan_hit) begin
               cmd.rd_scan = 1'b1;
               from_q_in   = 1'b0;
               state_in    = S_EXEC;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            unique case (st.ex)
               pvm_pkg::EX_SPLIT: begin
                  state_in = S_ADD2;
               end
               pvm_pkg::EX_MATCH: begin
                  ev_in    = pvm_pkg::EV_MATCH;
                  state_in = S_DONE;
               end
               pvm_pkg::EX_FKIND: begin
                  ev_in    = pvm_pkg::EV_FAULT_KIND;
                  state_in = S_DONE;
               end
               default: begin
                  state_in = from_q_ff ? S_QREAD : S_SCAN;
               end
            endcase
         end
         S_ADD2: begin
            cmd.add2 = 1'b1;
            state_in = from_q_ff ? S_QREAD : S_SCAN;
         end
         S_QREAD: begin
            if (st.q_empty) begin
               ev_in    = pvm_pkg::EV_NONE;
               state_in = S_DONE;
            end else begin
               cmd.q_rd = 1'b1;
               state_in = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (st.q_fault) begin
               ev_in    = pvm_pkg::EV_FAULT_PC;
               state_in = S_DONE;
            end else begin
               cmd.rd_q  = 1'b1;
               from_q_in = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_DONE: begin
            cmd.commit = 1'b1;
            cmd.ev     = ev_ff;
            state_in   = st.at_end ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            // Wait here only while the previous result beat is still held.
            if (!st.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ev_ff     <= pvm_pkg::EV_NONE;
         from_q_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ev_ff     <= ev_in;
         from_q_ff <= from_q_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pvm_datapath.sv =====
// ----------------------------------------------------------------------------
// pvm_datapath: storage and arithmetic of the Pike VM regex matcher
// Holds the program store, the thread sets, the visited marks, the work
// queue, the configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvm_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pvm_pkg::pvm_cmd_type                  cmd,
   output pvm_pkg::pvm_status_type                    st,
   input  wire logic                                  csr_write_en,
   input  wire logic [pvm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [pvm_pkg::CSR_W-1:0]             csr_wdata,
   input  wire logic [1:0]                            req_action,
   input  wire logic [pvm_pkg::IDX_W-1:0]             req_instr_index,
   input  wire logic [pvm_pkg::KIND_W-1:0]            req_instr_kind,
   input  wire logic [pvm_pkg::CHAR_W-1:0]            req_instr_char,
   input  wire logic signed [pvm_pkg::OFF_W-1:0]      req_instr_offset,
   input  wire logic [pvm_pkg::CHAR_W-1:0]            req_text_byte,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_matched,
   output logic [1:0]                                 rsp_fault_code
);

   localparam int PD = pvm_pkg::PROG_DEPTH;

   // Memories.
   logic [pvm_pkg::INSTR_W-1:0] store_mem [PD];
   logic [pvm_pkg::PC_W:0]      q_mem [pvm_pkg::QDEPTH];

   // Configuration.
   logic                        partial_ff;
   logic [pvm_pkg::PLEN_W-1:0]  plen_ff;

   // Architectural match state.
   logic [PD:0]                 active_ff;
   logic                        match_seen_ff;
   logic [1:0]                  fault_ff;

   // Walk state.
   logic [PD:0]                 next_ff;
   logic [PD-1:0]               work_ff;
   logic [PD-1:0]               seen_ff;
   logic                        high_ff;
   logic                        fq_ff;
   logic [pvm_pkg::LEN_W-1:0]   scan_ff;
   logic [pvm_pkg::QC_W-1:0]    head_ff;
   logic [pvm_pkg::QC_W-1:0]    tail_ff;
   logic [pvm_pkg::PC_W:0]      q_rd_ff;
   logic [pvm_pkg::INSTR_W-1:0] instr_ff;
   logic [pvm_pkg::PC_W-1:0]    cur_pc_ff;
   logic                        at_end_ff;
   logic [pvm_pkg::CHAR_W-1:0]  byte_ff;

   // Result register.
   logic                        rsp_valid_ff;
   logic                        rsp_matched_ff;
   logic [1:0]                  rsp_fault_ff;

   // Combinational signals.
   logic [pvm_pkg::LEN_W-1:0]          len;
   logic [PD:0]                        work;
   logic [PD:0]                        mask;
   logic [pvm_pkg::LD_W-1:0]           idx_wide;
   logic                               load_ok;
   logic [pvm_pkg::PC_W-1:0]           scan_pc;
   logic [pvm_pkg::PC_W-1:0]           q_pc;
   logic [pvm_pkg::PC_W-1:0]           rd_addr;
   logic [pvm_pkg::KIND_W-1:0]         kind;
   logic [pvm_pkg::CHAR_W-1:0]         ch;
   logic [pvm_pkg::OFF_W-1:0]          off;
   logic [1:0]                         ex;
   logic                               set_next;
   logic                               add_en;
   logic                               use_off;
   logic signed [pvm_pkg::TGT_W-1:0]   pc_s;
   logic signed [pvm_pkg::TGT_W-1:0]   off_s;
   logic signed [pvm_pkg::TGT_W-1:0]   len_s;
   logic signed [pvm_pkg::TGT_W-1:0]   tgt;
   logic                               tgt_out;
   logic [pvm_pkg::PC_W-1:0]           tgt_idx;
   logic [pvm_pkg::LEN_W-1:0]          nxt_idx;
   logic                               add_fault;
   logic                               add_pc;
   logic                               q_wr;
   logic [pvm_pkg::PC_W:0]             q_wdata;

   // A length above the store depth saturates.
   always_comb begin
      if (pvm_pkg::CMP_W'(plen_ff) > pvm_pkg::CMP_W'(PD)) begin
         len = pvm_pkg::LEN_W'(PD);
      end else begin
         len = pvm_pkg::LEN_W'(plen_ff);
      end
   end

   always_comb begin
      work = active_ff;
      if (partial_ff) begin
         work[0] = 1'b1;
      end
      for (int i = 0; i <= PD; i++) begin
         mask[i] = (i < int'(len));
      end
   end

   assign idx_wide = pvm_pkg::LD_W'(req_instr_index);
   assign load_ok  = (idx_wide < pvm_pkg::LD_W'(PD));
   assign scan_pc  = scan_ff[pvm_pkg::PC_W-1:0];
   assign q_pc     = q_rd_ff[pvm_pkg::PC_W-1:0];
   assign rd_addr  = cmd.rd_q ? q_pc : scan_pc;

   assign kind = instr_ff[pvm_pkg::INSTR_W-1 -: pvm_pkg::KIND_W];
   assign ch   = instr_ff[pvm_pkg::OFF_W +: pvm_pkg::CHAR_W];
   assign off  = instr_ff[pvm_pkg::OFF_W-1:0];

   always_comb begin
      ex       = pvm_pkg::EX_CONT;
      set_next = 1'b0;
      add_en   = cmd.add2;
      use_off  = cmd.add2;
      unique case (kind)
         pvm_pkg::KIND_LIT: begin
            set_next = cmd.exec && !at_end_ff && (ch == byte_ff);
         end
         pvm_pkg::KIND_WILD: begin
            set_next = cmd.exec && !at_end_ff;
         end
         pvm_pkg::KIND_JUMP: begin
            if (cmd.exec) begin
               add_en  = 1'b1;
               use_off = 1'b1;
            end
         end
         pvm_pkg::KIND_SPLIT: begin
            ex = pvm_pkg::EX_SPLIT;
            // The fall-through target goes first, the offset one next cycle.
            if (cmd.exec) begin
               add_en = 1'b1;
            end
         end
         pvm_pkg::KIND_MATCH: begin
            if (partial_ff || at_end_ff) begin
               ex = pvm_pkg::EX_MATCH;
            end
         end
         default: begin
            ex = pvm_pkg::EX_FKIND;
         end
      endcase
   end

   assign pc_s    = $signed(pvm_pkg::TGT_W'(cur_pc_ff));
   assign off_s   = {{(pvm_pkg::TGT_W - pvm_pkg::OFF_W){off[pvm_pkg::OFF_W-1]}}, off};
   assign len_s   = $signed(pvm_pkg::TGT_W'(len));
   assign tgt     = pc_s + (use_off ? off_s : pvm_pkg::TGT_W'(1));
   assign tgt_out = (tgt < 0) || (tgt >= len_s);
   assign tgt_idx = tgt[pvm_pkg::PC_W-1:0];
   assign nxt_idx = pvm_pkg::LEN_W'(cur_pc_ff) + pvm_pkg::LEN_W'(1);

   // Only one out-of-range entry is ever queued in a walk.
   assign add_fault = add_en && tgt_out && !fq_ff;
   assign add_pc    = add_en && !tgt_out && !seen_ff[tgt_idx];
   assign q_wr      = add_fault || add_pc;
   assign q_wdata   = {add_fault, tgt_idx};

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         store_mem[idx_wide[pvm_pkg::PC_W-1:0]] <=
            {req_instr_kind, req_instr_char, req_instr_offset};
      end
      if (cmd.rd_scan || cmd.rd_q) begin
         instr_ff  <= store_mem[rd_addr];
         cur_pc_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr) begin
         q_mem[tail_ff[pvm_pkg::QA_W-1:0]] <= q_wdata;
      end
      if (cmd.q_rd) begin
         q_rd_ff <= q_mem[head_ff[pvm_pkg::QA_W-1:0]];
      end
   end

   // Walk registers, all set up when a walk opens.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         work_ff   <= work[PD-1:0] & mask[PD-1:0];
         seen_ff   <= work[PD-1:0] & mask[PD-1:0];
         high_ff   <= |(work & ~mask);
         fq_ff     <= |(work & ~mask);
         next_ff   <= '0;
         scan_ff   <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         at_end_ff <= (req_action == pvm_pkg::ACT_END);
         byte_ff   <= req_text_byte;
      end else begin
         if (cmd.scan_next || cmd.rd_scan) begin
            scan_ff <= scan_ff + pvm_pkg::LEN_W'(1);
         end
         if (cmd.q_rd) begin
            head_ff <= head_ff + pvm_pkg::QC_W'(1);
         end
         if (q_wr) begin
            tail_ff <= tail_ff + pvm_pkg::QC_W'(1);
         end
         if (add_fault) begin
            fq_ff <= 1'b1;
         end
         if (add_pc) begin
            seen_ff[tgt_idx] <= 1'b1;
         end
         if (set_next) begin
            next_ff[nxt_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 1'b0;
         plen_ff    <= pvm_pkg::PLEN_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            pvm_pkg::CSR_PARTIAL_MODE: begin
               partial_ff <= csr_wdata[0];
            end
            pvm_pkg::CSR_PROGRAM_LENGTH: begin
               plen_ff <= csr_wdata;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= (PD + 1)'(1);
         match_seen_ff <= 1'b0;
         fault_ff      <= pvm_pkg::FAULT_NONE;
      end else if (cmd.commit) begin
         active_ff <= next_ff;
         case (cmd.ev)
            pvm_pkg::EV_MATCH:      match_seen_ff <= 1'b1;
            pvm_pkg::EV_FAULT_PC:   fault_ff      <= pvm_pkg::FAULT_PC;
            pvm_pkg::EV_FAULT_KIND: fault_ff      <= pvm_pkg::FAULT_KIND;
            default: begin
            end
         endcase
      end else if (cmd.emit) begin
         active_ff     <= (PD + 1)'(1);
         match_seen_ff <= 1'b0;
         fault_ff      <= pvm_pkg::FAULT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_matched_ff <= match_seen_ff && (fault_ff == pvm_pkg::FAULT_NONE);
         rsp_fault_ff   <= fault_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_fault_code = rsp_fault_ff;

   assign st.decided   = match_seen_ff || (fault_ff != pvm_pkg::FAULT_NONE);
   assign st.scan_done = (scan_ff >= len);
   assign st.scan_hit  = work_ff[scan_pc];
   assign st.high      = high_ff;
   assign st.q_empty   = (head_ff == tail_ff);
   assign st.q_fault   = q_rd_ff[pvm_pkg::PC_W];
   assign st.ex        = ex;
   assign st.at_end    = at_end_ff;
   assign st.out_busy  = rsp_valid_ff && rsp_stall;

endmodule

`default_nettype wire

// ===== design/pike_vm_regex_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// pike_vm_regex_matcher_unit: NFA regex matcher over a loaded program
// Load beat, or text beat once decided: taken in idle with no walk. A walk scans
// the thread set, executing each initial thread found, then each queued thread,
// plus a second add per split, a queue-empty check and a commit, serialised by the
// one read port of the store. End of text: result loaded, waits while one is held.
// Reset: thread set to pc 0 only, registers to defaults; store not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pike_vm_regex_matcher_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_action,
   input  wire logic [pvm_pkg::IDX_W-1:0]         req_instr_index,
   input  wire logic [pvm_pkg::KIND_W-1:0]        req_instr_kind,
   input  wire logic [pvm_pkg::CHAR_W-1:0]        req_instr_char,
   input  wire logic signed [pvm_pkg::OFF_W-1:0]  req_instr_offset,
   input  wire logic [pvm_pkg::CHAR_W-1:0]        req_text_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_matched,
   output logic [1:0]                             rsp_fault_code,
   input  wire logic                              csr_write_en,
   input  wire logic [pvm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pvm_pkg::CSR_W-1:0]         csr_wdata
);

   pvm_pkg::pvm_cmd_type    cmd;
   pvm_pkg::pvm_status_type st;

   pvm_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .st         (st),
      .cmd        (cmd)
   );

   pvm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_action       (req_action),
      .req_instr_index  (req_instr_index),
      .req_instr_kind   (req_instr_kind),
      .req_instr_char   (req_instr_char),
      .req_instr_offset (req_instr_offset),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .rsp_fault_code   (rsp_fault_code)
   );

   // A new result must never overwrite a beat that is still held.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // Once a walk opens, no further request beat is taken.
   a_walk_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("request accepted during a walk");

   // The store, the queue and the thread set see one operation per cycle.
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rd_scan, cmd.rd_q, cmd.q_rd, cmd.exec, cmd.add2,
                cmd.commit, cmd.emit}))
      else $error("overlapping datapath operations");

   // A faulted walk never reports a match.
   a_match_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched) |-> (rsp_fault_code == pvm_pkg::FAULT_NONE))
      else $error("match reported together with a fault");

endmodule

`default_nettype wire

// ===== bench/pike_vm_regex_matcher_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pike_vm_regex_matcher_unit_test: self-checking bench for the NFA matcher
// Fills the program store, runs short directed programs for each instruction
// kind, both modes and both fault codes, then runs random pattern programs
// with texts built to follow them. A thread-set predictor gives the expected
// outcome of every end-of-text beat, and a checker compares each result.
// ----------------------------------------------------------------------------

module pike_vm_regex_matcher_unit_test;

   localparam int CLK_HALF      = 6;
   localparam int SETTLE_CYCLES = 700;
   localparam int ITEM_GOAL     = 1650;
   localparam int LIMIT_NS      = 80_000_000;

   localparam logic [1:0]                 ACT_NONE = 2'd3;
   localparam logic [pvm_pkg::KIND_W-1:0] KIND_BAD = 3'd7;
   localparam logic [pvm_pkg::CHAR_W-1:0] CHAR_A   = 8'h61;

   typedef struct packed {
      logic       matched;
      logic [1:0] fault_code;
   } outcome_type;

   typedef enum int {PAT_LIT, PAT_ANY, PAT_OPT, PAT_STAR, PAT_PLUS} pat_elem_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [1:0]                        req_action = pvm_pkg::ACT_LOAD;
   logic [pvm_pkg::IDX_W-1:0]         req_instr_index = '0;
   logic [pvm_pkg::KIND_W-1:0]        req_instr_kind = pvm_pkg::KIND_LIT;
   logic [pvm_pkg::CHAR_W-1:0]        req_instr_char = '0;
   logic signed [pvm_pkg::OFF_W-1:0]  req_instr_offset = '0;
   logic [pvm_pkg::CHAR_W-1:0]        req_text_byte = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_matched;
   logic [1:0]                        rsp_fault_code;
   logic                              csr_write_en = 1'b0;
   logic [pvm_pkg::CSR_IDX_W-1:0]     csr_index = pvm_pkg::CSR_PARTIAL_MODE;
   logic [pvm_pkg::CSR_W-1:0]         csr_wdata = '0;

   // Predictor state.
   logic [pvm_pkg::KIND_W-1:0]        prog_kind [pvm_pkg::PROG_DEPTH];
   logic [pvm_pkg::CHAR_W-1:0]        prog_char [pvm_pkg::PROG_DEPTH];
   logic signed [pvm_pkg::OFF_W-1:0]  prog_off [pvm_pkg::PROG_DEPTH];
   logic [pvm_pkg::PROG_DEPTH:0]      thread_set = 1;
   bit                                match_seen = 1'b0;
   logic [1:0]                        fault_seen = pvm_pkg::FAULT_NONE;
   bit                                cfg_partial = 1'b0;
   logic [pvm_pkg::CSR_W-1:0]         cfg_len = 1;
   int                                walk_q[$];
   bit [pvm_pkg::PROG_DEPTH-1:0]      walk_visited;
   bit                                walk_fault;

   outcome_type                       outcome_q[$];
   int                                mismatch_count = 0;
   int                                beats_sent = 0;
   int                                rx_hold = 0;
   bit                                tx_quiet = 1'b0;
   bit                                rx_quiet = 1'b0;

   pike_vm_regex_matcher_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_instr_index  (req_instr_index),
      .req_instr_kind   (req_instr_kind),
      .req_instr_char   (req_instr_char),
      .req_instr_offset (req_instr_offset),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .rsp_fault_code   (rsp_fault_code),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Thread-set predictor
   // ------------------------------------------------------------------

   // A target outside the program stands for a single fault thread per walk.
   function automatic void enqueue_target(input int target, input int len);
      if (target < 0 || target >= len) begin
         if (!walk_fault && walk_q.size() < pvm_pkg::QDEPTH) begin
            walk_fault = 1'b1;
            walk_q = {walk_q, -1};
         end
      end else if (!walk_visited[target] && walk_q.size() < pvm_pkg::QDEPTH) begin
         walk_visited[target] = 1'b1;
         walk_q = {walk_q, target};
      end
   endfunction

   function automatic logic [1:0] step_threads(input bit at_end,
                                               input logic [pvm_pkg::CHAR_W-1:0] ch);
      logic [pvm_pkg::PROG_DEPTH:0] nxt;
      int                           len;
      int                           pc;
      int                           head;
      bit                           high;
      logic [1:0]                   ev;
      nxt = '0;
      high = 1'b0;
      ev = pvm_pkg::EV_NONE;
      len = int'(cfg_len);
      if (len > pvm_pkg::PROG_DEPTH) len = pvm_pkg::PROG_DEPTH;
      walk_q.delete();
      walk_visited = '0;
      walk_fault = 1'b0;
      if (cfg_partial) thread_set[0] = 1'b1;
      for (int i = 0; i <= pvm_pkg::PROG_DEPTH; i++) begin
         if (thread_set[i]) begin
            if (i < len) enqueue_target(i, len);
            else high = 1'b1;
         end
      end
      if (high) enqueue_target(-1, len);
      for (head = 0; head < walk_q.size() && ev == pvm_pkg::EV_NONE; head++) begin
         pc = walk_q[head];
         if (pc < 0) begin
            ev = pvm_pkg::EV_FAULT_PC;
         end else begin
            case (prog_kind[pc])
               pvm_pkg::KIND_LIT: begin
                  if (!at_end && prog_char[pc] == ch) nxt[pc + 1] = 1'b1;
               end
               pvm_pkg::KIND_WILD: begin
                  if (!at_end) nxt[pc + 1] = 1'b1;
               end
               pvm_pkg::KIND_JUMP: enqueue_target(pc + int'(prog_off[pc]), len);
               pvm_pkg::KIND_SPLIT: begin
                  enqueue_target(pc + 1, len);
                  enqueue_target(pc + int'(prog_off[pc]), len);
               end
               pvm_pkg::KIND_MATCH: begin
                  if (cfg_partial || at_end) ev = pvm_pkg::EV_MATCH;
               end
               default: ev = pvm_pkg::EV_FAULT_KIND;
            endcase
         end
      end
      thread_set = nxt;
      return ev;
   endfunction

   function automatic void record_event(input logic [1:0] ev);
      if (ev == pvm_pkg::EV_MATCH) match_seen = 1'b1;
      else if (ev == pvm_pkg::EV_FAULT_PC) fault_seen = pvm_pkg::FAULT_PC;
      else if (ev == pvm_pkg::EV_FAULT_KIND) fault_seen = pvm_pkg::FAULT_KIND;
   endfunction

   function automatic void predict_beat(input logic [1:0] act,
                                        input logic [pvm_pkg::IDX_W-1:0] idx,
                                        input logic [pvm_pkg::KIND_W-1:0] kind,
                                        input logic [pvm_pkg::CHAR_W-1:0] ch,
                                        input logic signed [pvm_pkg::OFF_W-1:0] off,
                                        input logic [pvm_pkg::CHAR_W-1:0] tbyte);
      outcome_type o;
      case (act)
         pvm_pkg::ACT_LOAD: begin
            prog_kind[idx] = kind;
            prog_char[idx] = ch;
            prog_off[idx] = off;
         end
         pvm_pkg::ACT_TEXT: begin
            if (!match_seen && fault_seen == pvm_pkg::FAULT_NONE)
               record_event(step_threads(1'b0, tbyte));
         end
         pvm_pkg::ACT_END: begin
            if (!match_seen && fault_seen == pvm_pkg::FAULT_NONE)
               record_event(step_threads(1'b1, '0));
            o.matched = match_seen && fault_seen == pvm_pkg::FAULT_NONE;
            o.fault_code = fault_seen;
            outcome_q = {outcome_q, o};
            thread_set = 1;
            match_seen = 1'b0;
            fault_seen = pvm_pkg::FAULT_NONE;
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result checker and receiver stalls
   // ------------------------------------------------------------------

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
   endfunction

   function automatic void check_outcome(input logic m, input logic [1:0] f);
      outcome_type want;
      if (outcome_q.size() == 0) begin
         note_mismatch($sformatf("result with nothing expected: matched=%0b fault=%0d", m, f));
      end else begin
         want = outcome_q.pop_front();
         if (m !== want.matched || f !== want.fault_code)
            note_mismatch($sformatf("expected matched=%0b fault=%0d, got matched=%0b fault=%0d",
                                    want.matched, want.fault_code, m, f));
      end
   endfunction

   // The hold counts down only while a result is waiting.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_outcome(rsp_matched, rsp_fault_code);
            rx_hold = rx_quiet ? 0 : $urandom_range(0, 11);
         end else if (rsp_valid && rx_hold > 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold > 0);
      end
   end

   // ------------------------------------------------------------------
   // Request driving
   // ------------------------------------------------------------------

   // Valid is left high after a beat so that back-to-back beats need no drop.
   task automatic send_beat(input logic [1:0] act, input logic [pvm_pkg::IDX_W-1:0] idx,
                            input logic [pvm_pkg::KIND_W-1:0] kind,
                            input logic [pvm_pkg::CHAR_W-1:0] ch,
                            input logic signed [pvm_pkg::OFF_W-1:0] off,
                            input logic [pvm_pkg::CHAR_W-1:0] tbyte);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_instr_index  <= idx;
      req_instr_kind   <= kind;
      req_instr_char   <= ch;
      req_instr_offset <= off;
      req_text_byte    <= tbyte;
      do @(posedge clock); while (req_stall);
      predict_beat(act, idx, kind, ch, off, tbyte);
      if (act != ACT_NONE) beats_sent++;
   endtask

   task automatic load_instr(input int idx, input logic [pvm_pkg::KIND_W-1:0] kind,
                             input logic [pvm_pkg::CHAR_W-1:0] ch,
                             input logic signed [pvm_pkg::OFF_W-1:0] off);
      send_beat(pvm_pkg::ACT_LOAD, pvm_pkg::IDX_W'(idx), kind, ch, off,
                pvm_pkg::CHAR_W'($urandom));
   endtask

   task automatic text_char(input logic [pvm_pkg::CHAR_W-1:0] b);
      send_beat(pvm_pkg::ACT_TEXT, pvm_pkg::IDX_W'($urandom), pvm_pkg::KIND_W'($urandom),
                pvm_pkg::CHAR_W'($urandom), pvm_pkg::OFF_W'($urandom), b);
   endtask

   task automatic end_text();
      send_beat(pvm_pkg::ACT_END, pvm_pkg::IDX_W'($urandom), pvm_pkg::KIND_W'($urandom),
                pvm_pkg::CHAR_W'($urandom), pvm_pkg::OFF_W'($urandom),
                pvm_pkg::CHAR_W'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcome_q.size() != 0);
   endtask

   task automatic write_csr(input logic [pvm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pvm_pkg::CSR_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx == pvm_pkg::CSR_PARTIAL_MODE) cfg_partial = val[0];
      else cfg_len = val;
   endtask

   // A text beat gives no result, so its walk may outlast the last result.
   task automatic reconfigure(input bit partial, input logic [pvm_pkg::CSR_W-1:0] len);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(pvm_pkg::CSR_PARTIAL_MODE, {(pvm_pkg::CSR_W-1)'($urandom), partial});
      write_csr(pvm_pkg::CSR_PROGRAM_LENGTH, len);
   endtask

   function automatic logic [pvm_pkg::CHAR_W-1:0] pick_char();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return pvm_pkg::CHAR_W'($urandom);
         default: return CHAR_A + pvm_pkg::CHAR_W'($urandom_range(0, 2));
      endcase
   endfunction

   function automatic int pattern_slots(input pat_elem_type pk);
      case (pk) inside
         PAT_STAR: return 3;
         PAT_OPT, PAT_PLUS: return 2;
         default: return 1;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every slot is written before any walk can read it.
   task automatic test_fill_store();
      for (int i = 0; i < pvm_pkg::PROG_DEPTH; i++)
         load_instr(i, pvm_pkg::KIND_W'($urandom), pvm_pkg::CHAR_W'($urandom),
                    pvm_pkg::OFF_W'($urandom));
   endtask

   task automatic test_literal_and_wildcard();
      reconfigure(1'b0, pvm_pkg::CSR_W'(3));
      load_instr(0, pvm_pkg::KIND_LIT, CHAR_A, '0);
      load_instr(1, pvm_pkg::KIND_WILD, '0, '0);
      load_instr(2, pvm_pkg::KIND_MATCH, '0, '0);
      text_char(CHAR_A);
      text_char(8'h7a);
      end_text();
      text_char(CHAR_A + 8'd1);
      end_text();
   endtask

   // Loop of the form (x)*y with the byte extremes as x and y.
   task automatic test_star_loop();
      reconfigure(1'b0, pvm_pkg::CSR_W'(5));
      load_instr(0, pvm_pkg::KIND_SPLIT, '0, pvm_pkg::OFF_W'(3));
      load_instr(1, pvm_pkg::KIND_LIT, '1, '0);
      load_instr(2, pvm_pkg::KIND_JUMP, '0, pvm_pkg::OFF_W'(-2));
      load_instr(3, pvm_pkg::KIND_LIT, '0, '0);
      load_instr(4, pvm_pkg::KIND_MATCH, '0, '0);
      text_char('1);
      text_char('1);
      text_char('0);
      end_text();
   endtask

   // Search mode: the match is found before the end beat, which then runs no walk.
   task automatic test_partial_search();
      reconfigure(1'b1, pvm_pkg::CSR_W'(5));
      text_char(8'd7);
      text_char('0);
      text_char(8'd9);
      end_text();
   endtask

   task automatic test_faults();
      reconfigure(1'b1, '0);
      end_text();
      reconfigure(1'b1, '1);
      load_instr(4, KIND_BAD, '0, '0);
      text_char('0);
      end_text();
      load_instr(2, pvm_pkg::KIND_JUMP, '0, pvm_pkg::OFF_W'(-64));
      text_char('1);
      text_char('1);
      send_beat(ACT_NONE, '1, '1, '1, '1, '1);
      end_text();
   endtask

   // Each round loads a small pattern program and runs texts shaped after it.
   task automatic run_pattern_round();
      pat_elem_type               elem_kind[$];
      logic [pvm_pkg::CHAR_W-1:0] elem_char[$];
      pat_elem_type               pk;
      int                         n_elem;
      int                         slots;
      int                         p;
      int                         reps;
      int                         n_texts;
      bit                         part;
      logic [pvm_pkg::CSR_W-1:0]  len_val;
      logic [pvm_pkg::CHAR_W-1:0] c;
      n_elem = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      slots = 0;
      repeat (n_elem) begin
         pk = pat_elem_type'($urandom_range(0, 4));
         if (slots + pattern_slots(pk) < pvm_pkg::PROG_DEPTH) begin
            elem_kind = {elem_kind, pk};
            elem_char = {elem_char, pick_char()};
            slots += pattern_slots(pk);
         end
      end
      part = 1'($urandom);
      case ($urandom_range(0, 11))
         0: len_val = '0;
         1: len_val = pvm_pkg::CSR_W'($urandom_range(pvm_pkg::PROG_DEPTH,
                                                      (1 << pvm_pkg::CSR_W) - 1));
         2: len_val = pvm_pkg::CSR_W'($urandom_range(1, slots + 1));
         default: len_val = pvm_pkg::CSR_W'(slots + 1);
      endcase
      reconfigure(part, len_val);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);

      p = 0;
      foreach (elem_kind[e]) begin
         case (elem_kind[e])
            PAT_LIT: load_instr(p, pvm_pkg::KIND_LIT, elem_char[e], pvm_pkg::OFF_W'($urandom));
            PAT_ANY: load_instr(p, pvm_pkg::KIND_WILD, pvm_pkg::CHAR_W'($urandom),
                                pvm_pkg::OFF_W'($urandom));
            PAT_OPT: begin
               load_instr(p, pvm_pkg::KIND_SPLIT, pvm_pkg::CHAR_W'($urandom),
                          pvm_pkg::OFF_W'(2));
               load_instr(p + 1, pvm_pkg::KIND_LIT, elem_char[e], pvm_pkg::OFF_W'($urandom));
            end
            PAT_STAR: begin
               load_instr(p, pvm_pkg::KIND_SPLIT, pvm_pkg::CHAR_W'($urandom),
                          pvm_pkg::OFF_W'(3));
               load_instr(p + 1, pvm_pkg::KIND_LIT, elem_char[e], pvm_pkg::OFF_W'($urandom));
               load_instr(p + 2, pvm_pkg::KIND_JUMP, pvm_pkg::CHAR_W'($urandom),
                          pvm_pkg::OFF_W'(-2));
            end
            default: begin
               load_instr(p, pvm_pkg::KIND_LIT, elem_char[e], pvm_pkg::OFF_W'($urandom));
               load_instr(p + 1, pvm_pkg::KIND_SPLIT, pvm_pkg::CHAR_W'($urandom),
                          pvm_pkg::OFF_W'(-1));
            end
         endcase
         p += pattern_slots(elem_kind[e]);
      end
      load_instr(p, pvm_pkg::KIND_MATCH, pvm_pkg::CHAR_W'($urandom), pvm_pkg::OFF_W'($urandom));
      // Now and then corrupt the program with arbitrary instructions.
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3))
            load_instr($urandom_range(0, p), pvm_pkg::KIND_W'($urandom),
                       pvm_pkg::CHAR_W'($urandom), pvm_pkg::OFF_W'($urandom));

      n_texts = $urandom_range(3, 8);
      repeat (n_texts) begin
         if (part || $urandom_range(0, 3) == 0)
            repeat ($urandom_range(0, 3)) text_char(pick_char());
         foreach (elem_kind[e]) begin
            case (elem_kind[e])
               PAT_OPT: reps = $urandom_range(0, 1);
               PAT_STAR: reps = $urandom_range(0, 3);
               PAT_PLUS: reps = $urandom_range(1, 3);
               default: reps = 1;
            endcase
            repeat (reps) begin
               if (elem_kind[e] == PAT_ANY) c = pvm_pkg::CHAR_W'($urandom);
               else if ($urandom_range(0, 11) == 0) c = pick_char();
               else c = elem_char[e];
               text_char(c);
            end
         end
         if (part || $urandom_range(0, 5) == 0)
            repeat ($urandom_range(0, 2)) text_char(pick_char());
         if ($urandom_range(0, 9) == 0)
            send_beat(ACT_NONE, pvm_pkg::IDX_W'($urandom), pvm_pkg::KIND_W'($urandom),
                      pvm_pkg::CHAR_W'($urandom), pvm_pkg::OFF_W'($urandom),
                      pvm_pkg::CHAR_W'($urandom));
         end_text();
         if ($urandom_range(0, 15) == 0) drain_results();
      end
   endtask

   task automatic test_random_patterns();
      while (beats_sent < ITEM_GOAL) run_pattern_round();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_store();
      test_literal_and_wildcard();
      test_star_loop();
      test_partial_search();
      test_faults();
      test_random_patterns();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
